// ===== src/rgcl_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, tables and types for the route great-circle length block
// no dependencies

package rgcl_pkg;

    localparam int CORDIC_ITERATIONS = 60;
    localparam int IDX_W = $clog2(CORDIC_ITERATIONS);
    localparam int TAB_DEPTH = 1 << IDX_W;

    localparam logic signed [63:0] Q_ONE = 64'sh1000_0000_0000_0000;
    localparam logic [63:0] PI_Q58 = 64'h0C90_FDAA_2216_8C23;
    localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] DEG_TO_RAD_Q61 = PI_Q61 / 64'd180;

    localparam int R_W = 36;
    localparam logic signed [R_W-1:0] TURN_Q24 = R_W'(64'd360 << 24);
    localparam logic signed [R_W-1:0] HALF_TURN_Q24 = R_W'(64'd180 << 24);

    localparam logic [32:0] TOTAL_MAX = 33'h1_FFFF_FFFF;
    localparam logic [31:0] OUT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] RADIUS_RESET = 32'd418014036;

    typedef logic signed [63:0] angle_tab_t [TAB_DEPTH];

    typedef struct packed {
        logic start;
        logic acos;
    } cord_req_t;

    // atan(2^-i) in q2.60 by truncated series terms
    function automatic angle_tab_t build_angle_tab();
        angle_tab_t tab;
        longint sum;
        longint term;
        int e;
        int k;
        tab[0] = PI_Q58;
        for (int i = 1; i < TAB_DEPTH; i++) begin
            sum = 0;
            k = 0;
            for (e = i; e <= 60; e += 2 * i) begin
                term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
                sum = k[0] ? sum - term : sum + term;
                k++;
            end
            tab[i] = sum;
        end
        return tab;
    endfunction

    // reciprocal of the double-rotation gain, truncated q2.60
    function automatic logic [63:0] calc_inv_gain();
        logic [63:0] g;
        logic [63:0] r;
        logic [63:0] q;
        g = Q_ONE;
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            if (2 * i < 63) g = g + (g >> (2 * i));
        end
        r = Q_ONE;
        q = '0;
        for (int n = 0; n < 60; n++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam angle_tab_t ANGLE_TAB = build_angle_tab();
    localparam logic signed [63:0] INV_GAIN = calc_inv_gain();

endpackage

// ===== src/rgcl_mul.sv =====
`timescale 1ns / 1ps
// 64x64 unsigned multiplier built from one 32x32 multiplier, four partial products accumulated in turn
// depends on rgcl_pkg (none of its items beyond the import)

module rgcl_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] product
);
    import rgcl_pkg::*;

    logic         busy_reg;
    logic         done_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] acc_reg;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [1:0]   sh_sel;
    logic [127:0] pp_shifted;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin a_half = a_reg[31:0];  b_half = b_reg[31:0];  sh_sel = 2'd0; end
            2'd1: begin a_half = a_reg[31:0];  b_half = b_reg[63:32]; sh_sel = 2'd1; end
            2'd2: begin a_half = a_reg[63:32]; b_half = b_reg[31:0];  sh_sel = 2'd1; end
            default: begin a_half = a_reg[63:32]; b_half = b_reg[63:32]; sh_sel = 2'd2; end
        endcase
        unique case (pp_sh_reg)
            2'd0: pp_shifted = {64'd0, pp_reg};
            2'd1: pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == 3'd4);
            if (start) begin
                a_reg     <= op_a;
                b_reg     <= op_b;
                pp_reg    <= '0;
                pp_sh_reg <= 2'd0;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                // accumulate the previous partial product while forming the next
                acc_reg   <= acc_reg + pp_shifted;
                pp_reg    <= 64'(a_half) * 64'(b_half);
                pp_sh_reg <= sh_sel;
                cnt_reg   <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== src/rgcl_cordic.sv =====
`timescale 1ns / 1ps
// shared double-rotation cordic: sine/cosine and arccosine, one rotation per cycle
// depends on rgcl_pkg for the angle table, gain and iteration count

module rgcl_cordic (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rgcl_pkg::cord_req_t     req,
    input  logic signed [63:0]      arg,
    output logic                    done,
    output logic signed [63:0]      x_out,
    output logic signed [63:0]      y_out,
    output logic signed [63:0]      ang_out
);
    import rgcl_pkg::*;

    logic                    busy_reg;
    logic                    done_reg;
    logic                    pass_reg;
    logic                    up_reg;
    logic                    acos_reg;
    logic [IDX_W-1:0]        i_reg;
    logic signed [63:0]      x_reg;
    logic signed [63:0]      y_reg;
    logic signed [63:0]      ang_reg;
    logic signed [63:0]      t_reg;
    logic                    up_now;
    logic signed [63:0]      dx;
    logic signed [63:0]      dy;
    logic signed [63:0]      two_a;
    logic [IDX_W:0]          t_sh;

    always_comb begin
        if (pass_reg) begin
            up_now = up_reg;
        end else if (acos_reg) begin
            up_now = (y_reg >= 0) ? (x_reg > t_reg) : (ang_reg < 0);
        end else begin
            up_now = (ang_reg >= 0);
        end
        dx    = y_reg >>> i_reg;
        dy    = x_reg >>> i_reg;
        two_a = ANGLE_TAB[i_reg] <<< 1;
        t_sh  = {i_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && pass_reg
                        && (i_reg == IDX_W'(CORDIC_ITERATIONS - 1));
            if (req.start) begin
                acos_reg <= req.acos;
                x_reg    <= req.acos ? Q_ONE : INV_GAIN;
                y_reg    <= '0;
                ang_reg  <= req.acos ? 64'sd0 : arg;
                t_reg    <= arg;
                i_reg    <= '0;
                pass_reg <= 1'b0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg <= up_now ? x_reg - dx : x_reg + dx;
                y_reg <= up_now ? y_reg + dy : y_reg - dy;
                if (!pass_reg) begin
                    up_reg   <= up_now;
                    pass_reg <= 1'b1;
                end else begin
                    pass_reg <= 1'b0;
                    ang_reg  <= (up_now != acos_reg) ? ang_reg - two_a : ang_reg + two_a;
                    // target tracks the gain while the shift still fits the word
                    if (t_sh < (IDX_W+1)'(63)) t_reg <= t_reg + (t_reg >>> t_sh);
                    i_reg <= i_reg + 1'b1;
                    if (i_reg == IDX_W'(CORDIC_ITERATIONS - 1)) begin
                        busy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    assign done    = done_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign ang_out = ang_reg;

endmodule

// ===== src/route_great_circle_length.sv =====
`timescale 1ns / 1ps
// route length over waypoints: four cordic runs per leg (three sine/cosine, one arccosine),
// seven multiplies per leg, each angle folded into one turn by 360 degree steps first;
// one waypoint at a time, not ready meanwhile.
// aresetn (synchronous, active low) clears the route state and sets the default radius.
// depends on rgcl_pkg, rgcl_mul and rgcl_cordic

module route_great_circle_length (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // latitude [31:0], longitude [64:32], zero pad
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // total_distance [31:0]
    output logic        m_axis_tuser    // saturated
);
    import rgcl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RED, S_HALF, S_MUL, S_MWAIT, S_CWAIT, S_FIN, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_DEG, OP_P1, OP_P2, OP_P3, OP_DIST
    } mop_t;

    state_t                 state_reg;
    mop_t                   mop_reg;
    logic [1:0]             k_reg;
    logic [31:0]            radius_reg;
    logic signed [31:0]     lat_reg;
    logic signed [32:0]     lon_reg;
    logic                   last_reg;
    logic signed [31:0]     prev_lat_reg;
    logic signed [32:0]     prev_lon_reg;
    logic                   have_prev_reg;
    logic [32:0]            total_reg;
    logic signed [R_W-1:0]  r_reg;
    logic signed [63:0]     ca_reg, sa_reg, cb_reg, sb_reg, cd_reg;
    logic signed [63:0]     p1_reg, p2_reg, th_reg;
    logic                   m_valid_reg;
    logic [31:0]            m_data_reg;
    logic                   m_user_reg;

    logic signed [63:0]     op_a, op_b;
    logic [63:0]            ua, ub;
    logic                   neg;
    logic                   mul_start, mul_done;
    logic [127:0]           mul_prod;
    logic [63:0]            msel;
    logic signed [63:0]     mres;
    logic signed [63:0]     arg_sum, arg_clamped;
    cord_req_t              cord_req;
    logic signed [63:0]     cord_arg;
    logic                   cord_done;
    logic signed [63:0]     cord_x, cord_y, cord_ang;
    logic [63:0]            sum_wide;
    logic signed [R_W-1:0]  lon_diff;

    always_comb begin
        unique case (mop_reg)
            OP_DEG:  begin op_a = 64'(r_reg);  op_b = DEG_TO_RAD_Q61; end
            OP_P1:   begin op_a = sa_reg;      op_b = sb_reg; end
            OP_P2:   begin op_a = ca_reg;      op_b = cb_reg; end
            OP_P3:   begin op_a = p2_reg;      op_b = cd_reg; end
            default: begin op_a = {32'd0, radius_reg}; op_b = th_reg; end
        endcase
        ua   = op_a[63] ? 64'd0 - op_a : op_a;
        ub   = op_b[63] ? 64'd0 - op_b : op_b;
        neg  = op_a[63] ^ op_b[63];
        msel = (mop_reg == OP_DEG) ? mul_prod[88:25] : mul_prod[123:60];
        mres = neg ? -$signed(msel) : $signed(msel);
        arg_sum = p1_reg + mres;
        if (arg_sum > Q_ONE) arg_clamped = Q_ONE;
        else if (arg_sum < -Q_ONE) arg_clamped = -Q_ONE;
        else arg_clamped = arg_sum;
        mul_start      = (state_reg == S_MUL);
        cord_req.start = (state_reg == S_MWAIT) && mul_done
                         && (mop_reg == OP_DEG || mop_reg == OP_P3);
        cord_req.acos  = (mop_reg == OP_P3);
        cord_arg       = (mop_reg == OP_DEG) ? mres : arg_clamped;
        sum_wide       = {31'd0, total_reg} + msel;
        lon_diff       = R_W'(prev_lon_reg) - R_W'(lon_reg);
    end

    rgcl_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (ua),
        .op_b    (ub),
        .done    (mul_done),
        .product (mul_prod)
    );

    rgcl_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cord_req),
        .arg     (cord_arg),
        .done    (cord_done),
        .x_out   (cord_x),
        .y_out   (cord_y),
        .ang_out (cord_ang)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mop_reg       <= OP_DEG;
            k_reg         <= '0;
            radius_reg    <= RADIUS_RESET;
            prev_lat_reg  <= '0;
            prev_lon_reg  <= '0;
            have_prev_reg <= 1'b0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) radius_reg <= cfg_wdata;
            if (m_valid_reg && m_axis_tready && state_reg != S_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        lat_reg  <= s_axis_tdata[31:0];
                        lon_reg  <= s_axis_tdata[64:32];
                        last_reg <= s_axis_tlast;
                        k_reg    <= '0;
                        r_reg    <= R_W'($signed(s_axis_tdata[31:0]));
                        mop_reg  <= OP_DEG;
                        state_reg <= have_prev_reg ? S_RED : S_FIN;
                    end
                end
                S_RED: begin
                    // fold into one turn, one add or subtract a cycle
                    if (r_reg < 0) r_reg <= r_reg + TURN_Q24;
                    else if (r_reg >= TURN_Q24) r_reg <= r_reg - TURN_Q24;
                    else state_reg <= S_HALF;
                end
                S_HALF: begin
                    if (r_reg >= HALF_TURN_Q24) r_reg <= r_reg - TURN_Q24;
                    mop_reg   <= OP_DEG;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        unique case (mop_reg)
                            OP_DEG: state_reg <= S_CWAIT;
                            OP_P1: begin
                                p1_reg    <= mres;
                                mop_reg   <= OP_P2;
                                state_reg <= S_MUL;
                            end
                            OP_P2: begin
                                p2_reg    <= mres;
                                mop_reg   <= OP_P3;
                                state_reg <= S_MUL;
                            end
                            OP_P3: state_reg <= S_CWAIT;
                            default: begin
                                total_reg <= (sum_wide > 64'(TOTAL_MAX)) ? TOTAL_MAX
                                                                          : sum_wide[32:0];
                                state_reg <= S_FIN;
                            end
                        endcase
                    end
                end
                S_CWAIT: begin
                    if (cord_done) begin
                        if (mop_reg == OP_P3) begin
                            th_reg    <= (cord_ang < 0) ? 64'sd0 : cord_ang;
                            mop_reg   <= OP_DIST;
                            state_reg <= S_MUL;
                        end else begin
                            unique case (k_reg)
                                2'd0: begin ca_reg <= cord_x; sa_reg <= cord_y; end
                                2'd1: begin cb_reg <= cord_x; sb_reg <= cord_y; end
                                default: cd_reg <= cord_x;
                            endcase
                            if (k_reg == 2'd2) begin
                                mop_reg   <= OP_P1;
                                state_reg <= S_MUL;
                            end else begin
                                r_reg     <= (k_reg == 2'd0) ? R_W'(prev_lat_reg) : lon_diff;
                                k_reg     <= k_reg + 2'd1;
                                state_reg <= S_RED;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (last_reg) begin
                        state_reg <= S_OUT;
                    end else begin
                        prev_lat_reg  <= lat_reg;
                        prev_lon_reg  <= lon_reg;
                        have_prev_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    if (!m_valid_reg || m_axis_tready) begin
                        m_valid_reg   <= 1'b1;
                        m_data_reg    <= total_reg[32] ? OUT_MAX : total_reg[31:0];
                        m_user_reg    <= total_reg[32];
                        prev_lat_reg  <= '0;
                        prev_lon_reg  <= '0;
                        have_prev_reg <= 1'b0;
                        total_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef NO_ASSERTIONS
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == S_MWAIT)
        else $error("multiplier finished outside its wait state");
    a_cord_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        cord_done |-> state_reg == S_CWAIT)
        else $error("cordic finished outside its wait state");
    a_total_needs_prev: assert property (@(posedge aclk) disable iff (!aresetn)
        !have_prev_reg |-> total_reg == '0)
        else $error("running total nonzero without a previous waypoint");
    a_out_clears_route: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && (!m_valid_reg || m_axis_tready)) |=>
            (m_valid_reg && !have_prev_reg))
        else $error("result issued without clearing the route");
`endif

endmodule

// ===== dv/route_great_circle_length_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for route_great_circle_length: waypoint routes in, route lengths out
// carries its own bit-exact cordic route-length calculator; depends on rgcl_pkg and the rtl

module route_great_circle_length_tb;
    import rgcl_pkg::*;

    localparam int ITERS = 60;
    localparam longint TURN = longint'(360) << 24;
    localparam logic [63:0] RAD_PER_DEG = 64'h6487_ED51_10B4_611A / 64'd180;
    localparam longint LAT_MAX = 1509949440;
    localparam longint LON_MAX = 3019898880;
    localparam longint RUN_MAX = 64'h1_FFFF_FFFF;
    localparam int SETTLE = 1200;
    // long enough that a finished route waits on the receiver and the next one stalls behind it
    localparam int HOLD_CYCLES = 8000;
    localparam int STUCK_LIMIT = 40000;

    typedef struct {
        logic [31:0] total;
        logic        sat;
    } route_total_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // latitude [31:0], longitude [64:32], zero pad
    logic        s_axis_tlast = 1'b0; // last_point
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // total_distance [31:0]
    logic        m_axis_tuser;        // saturated

    route_great_circle_length uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // calculator state
    longint       atan_tab [ITERS];
    longint       start_x;
    logic [31:0]  radius;
    longint       prev_lat;
    longint       prev_lon;
    bit           have_prev;
    longint       run_total;
    route_total_t pending_totals [$];

    int  errors = 0;
    bit  calm = 1'b0;
    int  hold_orders = 0;
    int  hold_done = 0;
    int  hold_left = 0;
    int  stuck = 0;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void build_tables();
        logic [63:0] g, r, q;
        longint sum, term;
        int k;
        atan_tab[0] = longint'(64'h0C90_FDAA_2216_8C23);
        for (int i = 1; i < ITERS; i++) begin
            sum = 0;
            k = 0;
            for (int e = i; e <= 60; e += 2 * i) begin
                term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
                sum = (k % 2) ? sum - term : sum + term;
                k++;
            end
            atan_tab[i] = sum;
        end
        g = 64'd1 << 60;
        for (int i = 0; i < ITERS; i++)
            if (2 * i < 63) g = g + (g >> (2 * i));
        r = 64'd1 << 60;
        q = '0;
        for (int n = 0; n < 60; n++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q[0] = 1'b1;
            end
        end
        start_x = longint'(q);
    endfunction

    // q2.60 product truncated toward zero
    function automatic longint mul_q(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0] ua, ub, m;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        m = p[123:60];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void twin_turn(inout longint x, inout longint y, input int i, input bit up);
        longint dx, dy;
        for (int p = 0; p < 2; p++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (up) begin
                x = x - dx;
                y = y + dy;
            end else begin
                x = x + dx;
                y = y - dy;
            end
        end
    endfunction

    function automatic void sin_cos(input longint z, output longint c, output longint s);
        longint x, y;
        bit up;
        x = start_x;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            up = (z >= 0);
            twin_turn(x, y, i, up);
            z = up ? z - 2 * atan_tab[i] : z + 2 * atan_tab[i];
        end
        c = x;
        s = y;
    endfunction

    function automatic longint arc_cos(input longint t);
        longint x, y, th;
        bit up;
        x = longint'(1) << 60;
        y = 0;
        th = 0;
        for (int i = 0; i < ITERS; i++) begin
            up = (y >= 0) ? (x > t) : (th < 0);
            twin_turn(x, y, i, up);
            th = up ? th + 2 * atan_tab[i] : th - 2 * atan_tab[i];
            if (2 * i < 63) t = t + (t >>> (2 * i));
        end
        return th;
    endfunction

    function automatic longint to_radians(input longint d);
        longint r;
        logic [63:0] mag;
        logic [127:0] p;
        r = d % TURN;
        if (r < 0) r += TURN;
        if (r >= TURN / 2) r -= TURN;
        mag = (r < 0) ? 64'(-r) : 64'(r);
        p = {64'd0, mag} * {64'd0, RAD_PER_DEG};
        return (r < 0) ? -longint'(p[88:25]) : longint'(p[88:25]);
    endfunction

    function automatic longint leg_length(input longint lat_a, input longint lon_a,
                                          input longint lat_b, input longint lon_b);
        longint sa, ca, sb, cb, cd, sd, arg, th;
        logic [127:0] p;
        sin_cos(to_radians(lat_a), ca, sa);
        sin_cos(to_radians(lat_b), cb, sb);
        sin_cos(to_radians(lon_b - lon_a), cd, sd);
        arg = mul_q(sa, sb) + mul_q(mul_q(ca, cb), cd);
        if (arg > (longint'(1) << 60)) arg = longint'(1) << 60;
        if (arg < -(longint'(1) << 60)) arg = -(longint'(1) << 60);
        th = arc_cos(arg);
        if (th < 0) th = 0;
        p = {96'd0, radius} * {64'd0, 64'(th)};
        return longint'(p[123:60]);
    endfunction

    function automatic void track_waypoint(input logic signed [31:0] lat,
                                           input logic signed [32:0] lon, input bit last);
        route_total_t res;
        if (have_prev) begin
            run_total += leg_length(longint'(lat), longint'(lon), prev_lat, prev_lon);
            if (run_total > RUN_MAX) run_total = RUN_MAX;
        end
        if (last) begin
            res.sat = (run_total > 64'hFFFF_FFFF);
            res.total = res.sat ? 32'hFFFF_FFFF : run_total[31:0];
            pending_totals.push_back(res);
            prev_lat = 0;
            prev_lon = 0;
            have_prev = 1'b0;
            run_total = 0;
        end else begin
            prev_lat = longint'(lat);
            prev_lon = longint'(lon);
            have_prev = 1'b1;
        end
    endfunction

    // sender: idles at random, then offers one waypoint until the transaction completes
    task automatic send_point(input logic [31:0] lat, input logic [32:0] lon, input bit last);
        if (!calm && $urandom_range(0, 99) < 24) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, lon, lat};
        s_axis_tlast <= last;
        do @(posedge aclk); while (!s_axis_tready);
        track_waypoint(lat, lon, last);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_totals.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_radius(input logic [31:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        radius = value;
    endtask

    function automatic logic [31:0] pick_lat();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return 32'(longint'($urandom_range(0, 32'(2 * LAT_MAX))) - LAT_MAX);
    endfunction

    function automatic logic [32:0] pick_lon();
        if ($urandom_range(0, 9) == 0) return {1'($urandom_range(0, 1)), 32'($urandom)};
        return 33'((longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF)
                   % (2 * LON_MAX + 1) - LON_MAX);
    endfunction

    task automatic test_single_points();
        send_point(32'd0, 33'd0, 1'b1);
        send_point(32'h8000_0000, 33'h1_0000_0000, 1'b1);
    endtask

    task automatic test_extremes();
        // pole to pole, then the date line seen from both sides
        send_point(32'(LAT_MAX), 33'd0, 1'b0);
        send_point(32'(-LAT_MAX), 33'd0, 1'b1);
        send_point(32'd0, 33'(LON_MAX), 1'b0);
        send_point(32'd0, 33'(-LON_MAX), 1'b1);
        // antipodes and a repeated point, where the argument leaves [-1,1]
        send_point(32'd0, 33'd0, 1'b0);
        send_point(32'd0, 33'(LON_MAX), 1'b0);
        send_point(32'd0, 33'(LON_MAX), 1'b1);
        // raw patterns far outside the degree range wrap around the circle
        send_point(32'h7FFF_FFFF, 33'h0_FFFF_FFFF, 1'b0);
        send_point(32'h8000_0000, 33'h1_0000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 33'h1_FFFF_FFFF, 1'b1);
    endtask

    task automatic test_saturation();
        set_radius(32'hFFFF_FFFF);
        send_point(32'd0, 33'd0, 1'b0);
        send_point(32'd0, 33'(LON_MAX), 1'b1);
        send_point(32'd0, 33'd0, 1'b0);
        send_point(32'd0, 33'(LON_MAX), 1'b0);
        send_point(32'd0, 33'd0, 1'b1);
        set_radius(32'd0);
        send_point(32'(LAT_MAX), 33'd0, 1'b0);
        send_point(32'(-LAT_MAX), 33'd5, 1'b1);
    endtask

    task automatic test_random_routes(input int count);
        int left, hops;
        left = count;
        while (left > 0) begin
            hops = $urandom_range(1, 6);
            for (int h = 0; h < hops && left > 0; h++) begin
                send_point(pick_lat(), pick_lon(), (h == hops - 1) || (left == 1));
                left--;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_orders++;
        test_random_routes(12);
        drain();
    endtask

    // receiver ready, with an occasional long hold-off
    always @(posedge aclk) begin
        if (hold_orders != hold_done) begin
            hold_done = hold_orders;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_totals.size() == 0) begin
                report($sformatf("unexpected total %h", m_axis_tdata));
            end else begin
                if (m_axis_tdata !== pending_totals[0].total)
                    report($sformatf("total %h, want %h", m_axis_tdata, pending_totals[0].total));
                if (m_axis_tuser !== pending_totals[0].sat)
                    report($sformatf("saturated %b, want %b", m_axis_tuser,
                                     pending_totals[0].sat));
                void'(pending_totals.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !aresetn)
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("route_great_circle_length verification failed");
            $finish;
        end
    end

    initial begin
        build_tables();
        radius = RADIUS_RESET;
        prev_lat = 0;
        prev_lon = 0;
        have_prev = 1'b0;
        run_total = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_points();
        test_extremes();
        test_saturation();
        test_backpressure();
        set_radius(RADIUS_RESET);
        test_random_routes(500);
        set_radius($urandom);
        calm = 1'b1;
        test_random_routes(200);
        calm = 1'b0;
        set_radius($urandom_range(1, 1000));
        test_random_routes(150);
        set_radius(32'hFFFF_FFFF);
        test_random_routes(150);
        test_backpressure();
        set_radius($urandom);
        test_random_routes(350);
        drain();

        if (errors == 0 && pending_totals.size() == 0) begin
            $display("route_great_circle_length verification clean");
        end else begin
            if (pending_totals.size() != 0)
                report($sformatf("%0d totals never arrived", pending_totals.size()));
            $display("route_great_circle_length verification failed");
        end
        $finish;
    end

endmodule

// ===== route_great_circle_length.f =====
src/rgcl_pkg.sv
src/rgcl_mul.sv
src/rgcl_cordic.sv
src/route_great_circle_length.sv
dv/route_great_circle_length_tb.sv
